// ===== hw/rtl/soa_pkg.sv =====
// Shared types and constants of the slab object allocator.
package soa_pkg;

  localparam int ADDR_W     = 16;
  localparam int SIZE_W     = 12;
  localparam int SPS_W      = 11;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int RCOUNT_W   = 5;
  localparam int DIVISOR_W  = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHRINK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSLAB  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADADDR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_SIZE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_PER_SLAB = 1'd1;

  localparam logic [SIZE_W-1:0] OBJECT_SIZE_RST    = 12'd16;
  localparam logic [SPS_W-1:0]  SLOTS_PER_SLAB_RST = 11'd227;

  localparam logic [RCOUNT_W-1:0] RCOUNT_MAX = 5'd31;

  typedef enum logic [1:0] {
    CLS_UNUSED  = 2'd0,
    CLS_FREE    = 2'd1,
    CLS_PARTIAL = 2'd2,
    CLS_FULL    = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_SHRINK = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
  } q_item_t;

endpackage

// ===== hw/rtl/soa_front.sv =====
// Request intake: classifies each item and holds it in a two-entry queue.
module soa_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [soa_pkg::MODE_W-1:0]   mode,
  input  logic [soa_pkg::ADDR_W-1:0]   object_address,
  output logic                         q_valid,
  output soa_pkg::q_item_t             q_item,
  input  logic                         q_pop
);
  import soa_pkg::*;

  q_item_t    entries [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       push;
  op_t        op_dec;

  always_comb begin
    unique case (mode)
      MODE_ALLOC:  op_dec = OP_ALLOC;
      MODE_FREE:   op_dec = OP_FREE;
      MODE_SHRINK: op_dec = OP_SHRINK;
      default:     op_dec = OP_NONE;
    endcase
  end

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = entries[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp].op   <= op_dec;
      entries[wp].addr <= object_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      if (push && !q_pop) fill <= fill + 2'd1;
      else if (q_pop && !push) fill <= fill - 2'd1;
    end
  end

endmodule

// ===== hw/rtl/soa_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
module soa_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [soa_pkg::ADDR_W-1:0]      dividend,
  input  logic [soa_pkg::DIVISOR_W-1:0]   divisor,
  output logic                            done,
  output logic [soa_pkg::ADDR_W-1:0]      quo,
  output logic [soa_pkg::ADDR_W-1:0]      rem
);
  import soa_pkg::*;

  localparam int CNT_W = $clog2(ADDR_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] dvs;
  logic [ADDR_W:0]      trial;
  logic                 fits;

  assign trial = {rem, quo[ADDR_W-1]};
  assign fits  = (trial >= dvs);

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      // remainder stays below the divisor, so it fits the dividend width
      rem <= fits ? ADDR_W'(trial - dvs) : ADDR_W'(trial);
      quo <= {quo[ADDR_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ADDR_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/soa_back.sv =====
// Request execution: slab scan, chain memory, address arithmetic and result register.
module soa_back #(
  parameter int NUM_SLABS  = 16,
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_SLOTS  = 2048
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [soa_pkg::SIZE_W-1:0]     object_size,
  input  logic [soa_pkg::SPS_W-1:0]      slots_per_slab,
  input  logic                           q_valid,
  input  soa_pkg::q_item_t               q_item,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [soa_pkg::ADDR_W-1:0]     result_address,
  output logic [soa_pkg::STATUS_W-1:0]   status,
  output logic [soa_pkg::RCOUNT_W-1:0]   released_count
);
  import soa_pkg::*;

  localparam int S_W   = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
  localparam int SL_W  = $clog2(MAX_SLOTS);
  localparam int CN_W  = $clog2(MAX_SLOTS + 1);
  localparam int MA_W  = $clog2(NUM_SLABS * MAX_SLOTS);
  localparam int DEPTH = NUM_SLABS * MAX_SLOTS;
  localparam int PR_W  = SL_W + SIZE_W;
  localparam int PG_SH = $clog2(PAGE_BYTES);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SCAN  = 10'b0000000010,
    S_PICK  = 10'b0000000100,
    S_CHAIN = 10'b0000001000,
    S_RD    = 10'b0000010000,
    S_CALC  = 10'b0000100000,
    S_DIVP  = 10'b0001000000,
    S_CHK   = 10'b0010000000,
    S_DIVS  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state;

  cls_t            cls     [NUM_SLABS];
  logic [CN_W-1:0] use_cnt [NUM_SLABS];
  logic [SL_W-1:0] head    [NUM_SLABS];
  logic [S_W-1:0]  rank    [NUM_SLABS];

  logic [SL_W-1:0] chain_mem [DEPTH];
  logic [SL_W-1:0] mem_rdata;
  logic            mem_we;
  logic [MA_W-1:0] mem_waddr;
  logic [SL_W-1:0] mem_wdata;
  logic [MA_W-1:0] mem_raddr;

  op_t             op;
  logic [S_W-1:0]  scan;
  logic [S_W-1:0]  s;
  logic            has_p, has_f, has_u;
  logic [S_W-1:0]  p_idx, f_idx, u_idx;
  logic [S_W-1:0]  p_rank, f_rank;
  logic [SL_W-1:0] ci;
  logic [PR_W-1:0] prod;
  logic            page_ok;
  logic [ADDR_W-1:0] off;
  logic [ADDR_W-1:0] req_addr;
  logic [31:0]       page_num;

  logic [ADDR_W-1:0]   res_addr;
  logic [STATUS_W-1:0] res_status;
  logic [RCOUNT_W-1:0] res_count;

  logic [S_W-1:0]  sel;
  cls_t            cur_cls;
  logic [S_W-1:0]  cur_rank;
  logic [CN_W-1:0] cur_use;
  logic [SL_W-1:0] cur_head;

  logic [16:0]       n17;
  logic [16:0]       two_n;
  logic [SIZE_W-1:0] size_eff;
  logic [MA_W-1:0]   base;
  logic [ADDR_W-1:0] page_base;
  logic              off_short;
  logic [ADDR_W-1:0] rel;
  logic              chk_ok;
  logic              chain_last;
  logic              free_ok;
  logic [SL_W-1:0]   free_slot;
  logic [CN_W-1:0]   use_inc;
  logic [CN_W-1:0]   use_dec;
  logic              do_touch;
  logic              out_load;

  logic                 div_start;
  logic [ADDR_W-1:0]    div_a;
  logic [DIVISOR_W-1:0] div_b;
  logic                 div_done;
  logic [ADDR_W-1:0]    div_quo;
  logic [ADDR_W-1:0]    div_rem;

  soa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // clamp the configured slot count and size to usable values
  always_comb begin
    n17 = 17'(slots_per_slab);
    if (n17 == 17'd0) n17 = 17'd1;
    else if (n17 > 17'(MAX_SLOTS)) n17 = 17'(MAX_SLOTS);
    size_eff = (object_size == '0) ? SIZE_W'(1) : object_size;
  end

  assign two_n = {n17[15:0], 1'b0};

  assign sel      = (state == S_SCAN) ? scan : s;
  assign cur_cls  = cls[sel];
  assign cur_rank = rank[sel];
  assign cur_use  = use_cnt[sel];
  assign cur_head = head[sel];

  assign base      = MA_W'(32'(s) * 32'(MAX_SLOTS));
  assign page_base = ADDR_W'(32'(s) * 32'(PAGE_BYTES));

  // page size is a power of two: slab index and offset are plain bit fields
  assign page_num = 32'(req_addr) >> PG_SH;

  assign off_short = ({1'b0, off} < two_n);
  assign rel       = off - ADDR_W'(two_n);
  assign chk_ok    = page_ok && (cur_cls == CLS_PARTIAL || cur_cls == CLS_FULL) && !off_short;

  assign chain_last = ((CN_W'(ci) + CN_W'(1)) == CN_W'(n17));
  assign free_ok    = (div_rem == '0) && ({1'b0, div_quo} < n17);
  assign free_slot  = SL_W'(div_quo);
  assign use_inc    = cur_use + CN_W'(1);
  assign use_dec    = (cur_use == '0) ? '0 : cur_use - CN_W'(1);

  assign q_pop = (state == S_IDLE) && q_valid;

  assign div_start = (state == S_CHK) && chk_ok;
  assign div_a     = rel;
  assign div_b     = DIVISOR_W'(size_eff);

  assign do_touch = (state == S_CALC) || (state == S_DIVS && div_done && free_ok);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = base + MA_W'(ci);
    mem_wdata = chain_last ? '0 : SL_W'(CN_W'(ci) + CN_W'(1));
    if (state == S_CHAIN) begin
      mem_we = 1'b1;
    end else if (state == S_DIVS && div_done && free_ok) begin
      mem_we    = 1'b1;
      mem_waddr = base + MA_W'(free_slot);
      mem_wdata = cur_head;
    end
  end

  assign mem_raddr = base + MA_W'(cur_head);

  always_ff @(posedge clk) begin
    if (mem_we) chain_mem[mem_waddr] <= mem_wdata;
    mem_rdata <= chain_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int t = 0; t < NUM_SLABS; t++) begin
        cls[t]     <= CLS_UNUSED;
        use_cnt[t] <= '0;
        head[t]    <= '0;
        rank[t]    <= S_W'(t);
      end
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            op         <= q_item.op;
            req_addr   <= q_item.addr;
            res_addr   <= '0;
            res_status <= ST_OK;
            res_count  <= '0;
            scan       <= '0;
            has_p      <= 1'b0;
            has_f      <= 1'b0;
            has_u      <= 1'b0;
            case (q_item.op)
              OP_ALLOC, OP_SHRINK: state <= S_SCAN;
              OP_FREE:             state <= S_DIVP;
              default:             state <= S_DONE;
            endcase
          end
        end

        S_SCAN: begin
          if (op == OP_SHRINK) begin
            if (cur_cls == CLS_FREE) begin
              cls[scan]     <= CLS_UNUSED;
              use_cnt[scan] <= '0;
              head[scan]    <= '0;
              if (res_count != RCOUNT_MAX) res_count <= res_count + RCOUNT_W'(1);
            end
          end else begin
            if (cur_cls == CLS_PARTIAL && (!has_p || cur_rank < p_rank)) begin
              has_p  <= 1'b1;
              p_idx  <= scan;
              p_rank <= cur_rank;
            end
            if (cur_cls == CLS_FREE && (!has_f || cur_rank < f_rank)) begin
              has_f  <= 1'b1;
              f_idx  <= scan;
              f_rank <= cur_rank;
            end
            if (cur_cls == CLS_UNUSED && !has_u) begin
              has_u <= 1'b1;
              u_idx <= scan;
            end
          end
          if (scan == S_W'(NUM_SLABS - 1)) begin
            state <= (op == OP_SHRINK) ? S_DONE : S_PICK;
          end else begin
            scan <= scan + S_W'(1);
          end
        end

        S_PICK: begin
          if (has_p) begin
            s     <= p_idx;
            state <= S_RD;
          end else if (has_f) begin
            s     <= f_idx;
            state <= S_RD;
          end else if (has_u) begin
            // take a fresh slab and chain its slots in order
            s              <= u_idx;
            cls[u_idx]     <= CLS_FREE;
            use_cnt[u_idx] <= '0;
            head[u_idx]    <= '0;
            ci             <= '0;
            state          <= S_CHAIN;
          end else begin
            res_status <= ST_NOSLAB;
            state      <= S_DONE;
          end
        end

        S_CHAIN: begin
          ci <= ci + SL_W'(1);
          if (chain_last) state <= S_RD;
        end

        S_RD: begin
          prod  <= PR_W'(cur_head) * PR_W'(size_eff);
          state <= S_CALC;
        end

        S_CALC: begin
          res_addr   <= page_base + ADDR_W'(two_n) + ADDR_W'(prod);
          use_cnt[s] <= use_inc;
          head[s]    <= mem_rdata;
          cls[s]     <= (17'(use_inc) >= n17) ? CLS_FULL : CLS_PARTIAL;
          state      <= S_DONE;
        end

        S_DIVP: begin
          page_ok <= (page_num < 32'(NUM_SLABS));
          s       <= (page_num < 32'(NUM_SLABS)) ? S_W'(page_num) : '0;
          off     <= ADDR_W'(32'(req_addr) & 32'(PAGE_BYTES - 1));
          state   <= S_CHK;
        end

        S_CHK: begin
          if (chk_ok) begin
            state <= S_DIVS;
          end else begin
            res_status <= ST_BADADDR;
            state      <= S_DONE;
          end
        end

        S_DIVS: begin
          if (div_done) begin
            if (free_ok) begin
              head[s]    <= free_slot;
              use_cnt[s] <= use_dec;
              cls[s]     <= (use_dec == '0) ? CLS_FREE : CLS_PARTIAL;
            end else begin
              res_status <= ST_BADADDR;
            end
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_load) begin
            result_address <= res_addr;
            status         <= res_status;
            released_count <= res_count;
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      // move the touched slab to the front of the recency order
      if (do_touch) begin
        for (int t = 0; t < NUM_SLABS; t++) begin
          if (rank[t] < rank[s]) rank[t] <= rank[t] + S_W'(1);
        end
        rank[s] <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/slab_object_allocator.sv =====
// Slab object allocator top level: configuration registers, intake queue and executor.
// One object cache over NUM_SLABS slabs of PAGE_BYTES each. Items pass through a
// two-entry queue to an executor that handles one item at a time; results leave
// through an output register, so intake continues while a result waits. An
// allocate scans every slab, one per cycle; when it opens an unused slab it also
// writes that slab's slot chain, one entry per cycle. A free takes slab and offset
// from the address bits, then runs one 16-step division on the serial divider to
// find the slot. Mode 3 returns an all-zero result. A stalled result holds the
// executor in its S_DONE state. The chain memory holds no reset value: entries
// are written when a slab is opened or a slot freed.
module slab_object_allocator #(
  parameter int NUM_SLABS  = 16,
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_SLOTS  = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [soa_pkg::MODE_W-1:0]        mode,
  input  logic [soa_pkg::ADDR_W-1:0]        object_address,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [soa_pkg::ADDR_W-1:0]        result_address,
  output logic [soa_pkg::STATUS_W-1:0]      status,
  output logic [soa_pkg::RCOUNT_W-1:0]      released_count,
  input  logic                              cfg_en,
  input  logic [soa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [soa_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import soa_pkg::*;

  logic [SIZE_W-1:0] object_size;
  logic [SPS_W-1:0]  slots_per_slab;
  logic              q_valid;
  q_item_t           q_item;
  logic              q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      object_size    <= OBJECT_SIZE_RST;
      slots_per_slab <= SLOTS_PER_SLAB_RST;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_OBJECT_SIZE:    object_size    <= cfg_data[SIZE_W-1:0];
        REG_SLOTS_PER_SLAB: slots_per_slab <= cfg_data[SPS_W-1:0];
        default: ;
      endcase
    end
  end

  soa_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .object_address (object_address),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  soa_back #(
    .NUM_SLABS  (NUM_SLABS),
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_SLOTS  (MAX_SLOTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .object_size    (object_size),
    .slots_per_slab (slots_per_slab),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_address (result_address),
    .status         (status),
    .released_count (released_count)
  );

  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_full_has_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid)
    else $error("intake stalled with empty queue");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (result_address == '0 && released_count == '0))
    else $error("failed item carries an address or count");

  a_count_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && released_count != '0) |-> (status == ST_OK && result_address == '0))
    else $error("shrink result mixed with allocate fields");

endmodule
